// ----- rtl/csq_pkg.sv -----
// Shared types and constants of the cursor sequence store.
`default_nettype none
package csq_pkg;

  localparam int WORD_W       = 64;
  localparam int KIND_W       = 3;
  localparam int COUNT_OUT_W  = 6;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 32;

  typedef enum logic [KIND_W-1:0] {
    K_START   = 3'd0,
    K_ADVANCE = 3'd1,
    K_INSERT  = 3'd2,
    K_ATTACH  = 3'd3,
    K_REMOVE  = 3'd4,
    K_QUERY   = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOCUR = 2'd2
  } status_t;

  // Row-wide shift command handed to every cell.
  typedef struct packed {
    logic ins;  // open a slot at the position, shift toward the back
    logic rem;  // close the slot at the position, shift toward the front
  } shift_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/csq_cell.sv -----
// One storage cell of the sequence row: holds a word and trades with its neighbors.
`default_nettype none
module csq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  wire logic                       clk,
  input  wire csq_pkg::shift_ctl_t        ctl,
  input  wire logic [CW-1:0]              pos,
  input  wire logic [csq_pkg::WORD_W-1:0] word,
  input  wire logic [csq_pkg::WORD_W-1:0] from_left,
  input  wire logic [csq_pkg::WORD_W-1:0] from_right,
  input  wire logic [CW-1:0]              cursor,
  output logic      [csq_pkg::WORD_W-1:0] value,
  output logic      [csq_pkg::WORD_W-1:0] sel_value
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [csq_pkg::WORD_W-1:0] value_r;
  logic [csq_pkg::WORD_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (MY_IDX > pos) begin
        value_nxt = from_left;
      end else if (MY_IDX == pos) begin
        value_nxt = word;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= pos) begin
        value_nxt = from_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value     = value_r;
  // Drive the word onto the read-out tree only when the cursor sits here.
  assign sel_value = (cursor == MY_IDX) ? value_r : '0;

endmodule
`default_nettype wire

// ----- rtl/cursor_sequence_store.sv -----
// Top level of the cursor sequence store: controller plus a row of storage cells.
`default_nettype none
// Usage
//   Input channel: drive in_kind and in_entry_value with start high; the item
//   is taken at a rising edge where start is high and busy is low. busy never
//   rises, so one item can be taken every cycle.
//   Kinds: start, advance, insert before cursor, attach after cursor, remove
//   current, query; the two unused codes act as a query.
//   Result channel: exactly one result per item, shown in the cycle right after
//   the item is taken, marked by out_valid for that one cycle. The receiver
//   cannot stall; a result not captured in its cycle is gone.
//   Throughput: 1 item per cycle, since the row of CAPACITY cells shifts the
//   words from the given position on by one place at once on insert, attach
//   or remove.
//   The current word is picked from the row by an AND-OR tree keyed by the
//   cursor register.
//   Reset (rst_n low, synchronous): count goes to zero and the cursor to "no
//   current entry"; cell contents are not cleared, since only entries below
//   the count are ever read.
//   Insert or attach into a full store drops the word and reports full.
module cursor_sequence_store #(
  parameter int CAPACITY = csq_pkg::DEF_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [csq_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [csq_pkg::WORD_W-1:0]      in_entry_value,
  output logic                                 out_valid,
  output logic      [csq_pkg::WORD_W-1:0]      out_current_value,
  output logic                                 out_has_current,
  output logic      [csq_pkg::COUNT_OUT_W-1:0] out_entry_count,
  output logic      [csq_pkg::STATUS_W-1:0]    out_status
);

  // Count and cursor both need to hold CAPACITY itself.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_V = CW'(1);

  logic                accept;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       cursor_r, cursor_nxt;
  logic                out_valid_r;
  csq_pkg::status_t    status_r, status_nxt;
  csq_pkg::shift_ctl_t ctl;
  logic [CW-1:0]       pos;
  logic                cur;
  logic                full;

  logic [csq_pkg::WORD_W-1:0] cell_val [CAPACITY];
  logic [csq_pkg::WORD_W-1:0] cell_sel [CAPACITY];
  logic [csq_pkg::WORD_W-1:0] read_word;

  // The row finishes every operation as the item is taken: never hold off an item.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign cur  = cursor_r < count_r;
  assign full = count_r >= CAP_V;

  // Decode the item into a shift command, the new count, cursor and status.
  always_comb begin
    ctl        = '0;
    pos        = '0;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = csq_pkg::ST_OK;
    if (accept) begin
      case (in_kind)
        csq_pkg::K_START: begin
          cursor_nxt = '0;
        end
        csq_pkg::K_ADVANCE: begin
          if (cur) begin
            cursor_nxt = cursor_r + ONE_V;
          end else begin
            status_nxt = csq_pkg::ST_NOCUR;
          end
        end
        csq_pkg::K_INSERT: begin
          if (full) begin
            status_nxt = csq_pkg::ST_FULL;
          end else begin
            pos        = cur ? cursor_r : '0;
            ctl.ins    = 1'b1;
            count_nxt  = count_r + ONE_V;
            cursor_nxt = pos;
          end
        end
        csq_pkg::K_ATTACH: begin
          if (full) begin
            status_nxt = csq_pkg::ST_FULL;
          end else begin
            pos        = cur ? (cursor_r + ONE_V) : count_r;
            ctl.ins    = 1'b1;
            count_nxt  = count_r + ONE_V;
            cursor_nxt = pos;
          end
        end
        csq_pkg::K_REMOVE: begin
          if (cur) begin
            // Close the gap; the following word slides under the cursor.
            pos       = cursor_r;
            ctl.rem   = 1'b1;
            count_nxt = count_r - ONE_V;
          end else begin
            status_nxt = csq_pkg::ST_NOCUR;
          end
        end
        default: begin
          // Query and unused codes: report only.
        end
      endcase
      // Park the cursor at "none" whenever it falls off the stored entries.
      if (cursor_nxt >= count_nxt) begin
        cursor_nxt = CAP_V;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= CAP_V;
      out_valid_r <= 1'b0;
      status_r    <= csq_pkg::ST_OK;
    end else begin
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= accept;
      if (accept) begin
        status_r <= status_nxt;
      end
    end
  end

  // Row of cells; the ends hand their own word back in where no neighbor exists.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [csq_pkg::WORD_W-1:0] left_w;
    logic [csq_pkg::WORD_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_val[g];
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_val[g];
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end
    csq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos),
      .word       (in_entry_value),
      .from_left  (left_w),
      .from_right (right_w),
      .cursor     (cursor_r),
      .value      (cell_val[g]),
      .sel_value  (cell_sel[g])
    );
  end

  // At most one cell drives a nonzero word; OR them together.
  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | cell_sel[i];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_has_current   = cur;
  assign out_current_value = cur ? read_word : '0;
  assign out_entry_count   = csq_pkg::COUNT_OUT_W'(count_r);
  assign out_status        = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_V)
    else $error("entry count above capacity");

  a_cursor_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r < count_r) || (cursor_r == CAP_V))
    else $error("cursor neither on an entry nor parked");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && ((in_kind == csq_pkg::K_INSERT) || (in_kind == csq_pkg::K_ATTACH)))
    |=> (count_r == $past(count_r)) && (out_status == csq_pkg::ST_FULL))
    else $error("write into full store changed the count");

endmodule
`default_nettype wire

// ----- bench/cursor_sequence_store_test.sv -----
// Self-checking testbench of the cursor sequence store: directed and random items with a mirror.
`default_nettype none
module cursor_sequence_store_test;
  import csq_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int ITEM_TOTAL  = 1950;
  localparam int STALL_LIMIT = 1000;

  // Random phase styles: grow toward full, shrink toward empty, or stir.
  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  // One result as the block should show it.
  typedef struct packed {
    logic [WORD_W-1:0]      word;
    logic                   live;
    logic [COUNT_OUT_W-1:0] cnt;
    status_t                st;
  } view_t;

  // Mirror of the store: own copy of the entries, count and cursor, plus the
  // queue of results still to arrive.
  class cursor_store_mirror;
    logic [WORD_W-1:0] cells [CAP];
    int unsigned       stored;
    int unsigned       cursor;
    view_t             views_due [$];
    int                mismatches;

    function new();
      stored     = 0;
      cursor     = CAP;
      mismatches = 0;
    endfunction

    // Apply one accepted item to the mirror and queue the result it causes.
    function void apply_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word);
      status_t     st;
      bit          live;
      int unsigned pos;
      int unsigned i;
      view_t       v;
      st   = ST_OK;
      live = cursor < stored;
      case (kind)
        K_START: begin
          cursor = 0;
        end
        K_ADVANCE: begin
          if (live) cursor++;
          else st = ST_NOCUR;
        end
        K_INSERT, K_ATTACH: begin
          if (stored >= CAP) begin
            st = ST_FULL;
          end else begin
            // Insert opens a slot at the cursor, attach one past it; with no
            // current entry they go to the front and the back.
            if (kind == K_INSERT) pos = live ? cursor : 0;
            else pos = live ? cursor + 1 : stored;
            for (i = stored; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = word;
            stored++;
            cursor = pos;
          end
        end
        K_REMOVE: begin
          if (!live) begin
            st = ST_NOCUR;
          end else begin
            // Close the gap; the following entry becomes current.
            for (i = cursor; i + 1 < stored; i++) cells[i] = cells[i+1];
            stored--;
          end
        end
        default: begin
        end
      endcase
      if (cursor >= stored) cursor = CAP;
      live   = cursor < stored;
      v.word = live ? cells[cursor] : '0;
      v.live = live;
      v.cnt  = stored[COUNT_OUT_W-1:0];
      v.st   = st;
      views_due.push_back(v);
    endfunction

    // Compare one result with the oldest expectation.
    function void compare_view(logic [WORD_W-1:0] word, logic live,
                               logic [COUNT_OUT_W-1:0] cnt, logic [STATUS_W-1:0] st);
      view_t want;
      if (views_due.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
        return;
      end
      want = views_due.pop_front();
      if (word !== want.word) begin
        $error("current_value expected %h got %h", want.word, word);
        mismatches++;
      end
      if (live !== want.live) begin
        $error("has_current expected %0d got %0d", want.live, live);
        mismatches++;
      end
      if (cnt !== want.cnt) begin
        $error("entry_count expected %0d got %0d", want.cnt, cnt);
        mismatches++;
      end
      if (st !== want.st) begin
        $error("status expected %0d got %0d", want.st, st);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   start          = 1'b0;
  logic [KIND_W-1:0]      in_kind        = K_QUERY;
  logic [WORD_W-1:0]      in_entry_value = '0;
  logic                   busy;
  logic                   out_valid;
  logic [WORD_W-1:0]      out_current_value;
  logic                   out_has_current;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic [STATUS_W-1:0]    out_status;

  cursor_store_mirror mirror = new();
  int                 items_sent  = 0;
  int                 burst_left  = 0;
  int                 stall_count = 0;

  cursor_sequence_store #(.CAPACITY(CAP)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_current_value(out_current_value),
    .out_has_current  (out_has_current),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Send one item. Between bursts drop start for a random gap (sometimes none); within a burst
  // hold start high so the next item follows back to back.
  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    start          <= 1'b1;
    in_kind        <= kind;
    in_entry_value <= word;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.apply_item(kind, word);
    items_sent++;
  endtask

  // Random word; now and then the extremes.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Pick an operation, weighted by the phase style. Unused codes stay rare.
  function automatic logic [KIND_W-1:0] pick_kind(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 38) return K_INSERT;
        if (r < 76) return K_ATTACH;
        if (r < 84) return K_ADVANCE;
        if (r < 90) return K_START;
        if (r < 95) return K_REMOVE;
        if (r < 98) return K_QUERY;
        return ($urandom_range(0, 1) == 0) ? 3'd6 : 3'd7;
      end
      PH_DRAIN: begin
        if (r < 50) return K_REMOVE;
        if (r < 65) return K_START;
        if (r < 77) return K_ADVANCE;
        if (r < 85) return K_INSERT;
        if (r < 93) return K_ATTACH;
        if (r < 97) return K_QUERY;
        return ($urandom_range(0, 1) == 0) ? 3'd6 : 3'd7;
      end
      default: begin
        if (r < 18) return K_INSERT;
        if (r < 36) return K_ATTACH;
        if (r < 54) return K_REMOVE;
        if (r < 70) return K_ADVANCE;
        if (r < 84) return K_START;
        if (r < 94) return K_QUERY;
        return ($urandom_range(0, 1) == 0) ? 3'd6 : 3'd7;
      end
    endcase
  endfunction

  // Check every result in the cycle it is shown; the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      mirror.compare_view(out_current_value, out_has_current, out_entry_count, out_status);
    end
  end

  // Count cycles with neither an item taken nor a result shown; give up at the limit.
  always @(posedge clk) begin
    if (rst_n && ((start && busy === 1'b0) || out_valid === 1'b1)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $error("no handshake for %0d cycles", STALL_LIMIT);
      $display("cursor_sequence_store_test NOT OK");
      $finish;
    end
  end

  initial begin
    phase_t ph;
    int     phase_idx;
    int     extra;
    int     span;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, no-current cases, front and back placement,
    // middle insert and attach, removal down to empty, unused codes.
    push_item(K_QUERY,   '0);
    push_item(K_START,   '1);
    push_item(K_ADVANCE, '0);
    push_item(K_REMOVE,  '0);
    push_item(K_INSERT,  '0);
    push_item(K_ATTACH,  '1);
    push_item(3'd6,      '1);
    push_item(3'd7,      '0);
    push_item(K_START,   '0);
    push_item(K_ADVANCE, '0);
    push_item(K_ADVANCE, '0);                         // step past the last entry
    push_item(K_ATTACH,  64'h0123_4567_89ab_cdef);    // no current: goes to the back
    push_item(K_ADVANCE, '0);
    push_item(K_INSERT,  64'hfedc_ba98_7654_3210);    // no current: goes to the front
    push_item(K_START,   '0);
    push_item(K_ADVANCE, '0);
    push_item(K_INSERT,  64'h8000_0000_0000_0001);
    push_item(K_ATTACH,  64'h7fff_ffff_ffff_fffe);
    push_item(K_REMOVE,  '0);
    push_item(K_START,   '0);
    repeat (5) push_item(K_REMOVE, '0);
    push_item(K_REMOVE,  '0);                         // nothing left to remove

    // Random: rotate fill, mix and drain phases. A fill phase runs until the
    // store is full and then keeps writing so dropped writes show up; a drain
    // phase runs until the store is empty and then pokes at it a while.
    phase_idx = 0;
    while (items_sent < ITEM_TOTAL) begin
      ph    = phase_t'(phase_idx % 3);
      span  = 0;
      extra = $urandom_range(3, 12);
      case (ph)
        PH_FILL: begin
          while (mirror.stored < CAP && span < 300) begin
            push_item(pick_kind(ph), pick_word());
            span++;
          end
          repeat (extra) push_item(pick_kind(ph), pick_word());
        end
        PH_DRAIN: begin
          while (mirror.stored > 0 && span < 300) begin
            push_item(pick_kind(ph), pick_word());
            span++;
          end
          repeat (extra) push_item(pick_kind(ph), pick_word());
        end
        default: begin
          repeat ($urandom_range(40, 160)) push_item(pick_kind(ph), pick_word());
        end
      endcase
      phase_idx++;
    end

    // Drain the results, then let the registered outputs settle.
    start <= 1'b0;
    while (mirror.views_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("cursor_sequence_store_test OK");
    end else begin
      $display("cursor_sequence_store_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/csq_pkg.sv
rtl/csq_cell.sv
rtl/cursor_sequence_store.sv
bench/cursor_sequence_store_test.sv
